FILE: design/pfb_pkg.sv
// shared types, constants and blend arithmetic for the 2x2 blend filter
package pfb_pkg;

  localparam int CFG_W = 11;
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int IDX_W = 20;
  localparam int POS_W = 2 * CFG_W;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = CFG_W'(640);
  localparam logic [CFG_W-1:0] LINE_COUNT_RST = CFG_W'(480);
  localparam logic [CFG_W-1:0] DIM_MIN        = CFG_W'(2);

  // row and column blend steps, as right shifts
  localparam int SHIFT_ROW = 2;
  localparam int SHIFT_COL = 3;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH = 2'd0,
    REG_LINE_COUNT = 2'd1
  } cfg_reg_t;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [PIX_W-1:0] pixel_t;

  // a + floor((b - a) / 2^sh); the result stays between a and b
  function automatic chan_t move_toward(chan_t a, chan_t b, int sh);
    logic signed [CH_W:0] diff;
    logic signed [CH_W:0] step;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    step = diff >>> sh;
    return a + step[CH_W-1:0];
  endfunction

  function automatic chan_t blend_chan(chan_t a, chan_t b, chan_t c, chan_t d);
    chan_t top;
    chan_t bot;
    top = move_toward(a, b, SHIFT_ROW);
    bot = move_toward(c, d, SHIFT_ROW);
    return move_toward(top, bot, SHIFT_COL);
  endfunction

endpackage

FILE: design/pixel_fade_blur_2x2.sv
// 2x2 blend filter over an rgb raster, with a one-line-plus-one-pixel store
// one item per cycle unless stalled; each result is registered in s1, then at the output
// the store has two read ports and one write port, all used at the accept edge
// a configuration write holds off items while a bit-serial
// remainder unit re-derives the store slot of the current position
// reset clears position, previous pixel, config and handshake state; store is not cleared
module pixel_fade_blur_2x2
  import pfb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_LINES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  // pixel items
  input  logic             pix_valid,
  output logic             pix_stall,
  input  logic             frame_start,
  input  logic [CH_W-1:0]  red_in,
  input  logic [CH_W-1:0]  green_in,
  input  logic [CH_W-1:0]  blue_in,
  // result items
  output logic             res_valid,
  input  logic             res_stall,
  output logic [IDX_W-1:0] pixel_index,
  output logic [CH_W-1:0]  red_out,
  output logic [CH_W-1:0]  green_out,
  output logic [CH_W-1:0]  blue_out,
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int MEM_DEPTH = MAX_WIDTH + 1;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int DW        = CFG_W + 1;
  localparam int CNT_W     = $clog2(POS_W + 1);
  localparam logic [CFG_W-1:0] WMAX = CFG_W'((MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH);
  localparam logic [CFG_W-1:0] HMAX = CFG_W'((MAX_LINES > 2047) ? 2047 : MAX_LINES);
  localparam logic [POS_W-1:0] TOTAL_RST = POS_W'(640 * 480);

  // configuration and derived sizes
  logic [CFG_W-1:0] line_width;
  logic [CFG_W-1:0] line_count;
  logic [CFG_W-1:0] wc;
  logic [CFG_W-1:0] hc;
  logic [DW-1:0]    depth;
  logic [POS_W-1:0] total;

  // position state
  logic [POS_W-1:0] position_count;
  logic [AW-1:0]    slot;
  pixel_t           previous_pixel;

  // slot remainder unit
  logic             mod_busy;
  logic [CNT_W-1:0] mod_cnt;
  logic [DW-1:0]    mod_rem;
  logic [POS_W-1:0] mod_dvd;
  logic [DW:0]      mod_trial;
  logic [DW-1:0]    mod_rem_next;

  // accept stage
  logic             accept;
  logic             wrap;
  logic [POS_W-1:0] q;
  logic [AW-1:0]    slot_q;
  logic [AW-1:0]    slot_b;
  logic [POS_W:0]   q_inc;
  logic             emit;
  logic [POS_W-1:0] p;
  pixel_t           pix;

  // store and stage after it
  pixel_t           store [MEM_DEPTH];
  pixel_t           rd_a;
  pixel_t           rd_b;
  logic             s1_valid;
  logic [IDX_W-1:0] s1_index;
  pixel_t           s1_c;
  pixel_t           s1_d;
  logic             out_free;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (line_width < DIM_MIN) begin
      wc = DIM_MIN;
    end else if (line_width > WMAX) begin
      wc = WMAX;
    end else begin
      wc = line_width;
    end
    if (line_count < DIM_MIN) begin
      hc = DIM_MIN;
    end else if (line_count > HMAX) begin
      hc = HMAX;
    end else begin
      hc = line_count;
    end
    depth = DW'(wc) + DW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
      line_count <= LINE_COUNT_RST;
      total      <= TOTAL_RST;
    end else begin
      total <= POS_W'(wc) * POS_W'(hc);
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_LINE_WIDTH: line_width <= cfg_data;
          REG_LINE_COUNT: line_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // one quotient bit per cycle: slot = position_count mod depth
  always_comb begin
    mod_trial = {mod_rem, mod_dvd[POS_W-1]};
    if (mod_trial >= (DW+1)'(depth)) begin
      mod_rem_next = DW'(mod_trial - (DW+1)'(depth));
    end else begin
      mod_rem_next = DW'(mod_trial);
    end
  end

  assign out_free  = !res_valid || !res_stall;
  assign pix_stall = mod_busy || cfg_valid || (s1_valid && !out_free);
  assign accept    = pix_valid && !pix_stall;

  always_comb begin
    pix    = {red_in, green_in, blue_in};
    wrap   = frame_start || (position_count >= total);
    q      = wrap ? '0 : position_count;
    slot_q = wrap ? '0 : slot;
    slot_b = (32'(slot_q) == 32'(wc)) ? '0 : slot_q + AW'(1);
    q_inc  = (POS_W+1)'(q) + (POS_W+1)'(1);
    emit   = q >= POS_W'(depth);
    p      = q - POS_W'(depth);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      slot           <= '0;
      previous_pixel <= '0;
      mod_busy       <= 1'b0;
      mod_cnt        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mod_busy <= 1'b1;
      mod_cnt  <= CNT_W'(POS_W);
      mod_rem  <= '0;
      mod_dvd  <= position_count;
    end else if (mod_busy) begin
      mod_rem <= mod_rem_next;
      mod_dvd <= mod_dvd << 1;
      mod_cnt <= mod_cnt - CNT_W'(1);
      if (mod_cnt == CNT_W'(1)) begin
        mod_busy <= 1'b0;
        slot     <= AW'(mod_rem_next);
      end
    end else if (accept) begin
      previous_pixel <= pix;
      if (q_inc >= (POS_W+1)'(total)) begin
        position_count <= '0;
        slot           <= '0;
      end else begin
        position_count <= q_inc[POS_W-1:0];
        slot           <= slot_b;
      end
    end
  end

  // line store: both reads see the contents before this item's write
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a          <= store[slot_q];
      rd_b          <= store[slot_b];
      store[slot_q] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emit;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_index <= p[IDX_W-1:0];
      s1_c     <= previous_pixel;
      s1_d     <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      pixel_index <= s1_index;
      red_out     <= blend_chan(rd_a[3*CH_W-1:2*CH_W], rd_b[3*CH_W-1:2*CH_W],
                                s1_c[3*CH_W-1:2*CH_W], s1_d[3*CH_W-1:2*CH_W]);
      green_out   <= blend_chan(rd_a[2*CH_W-1:CH_W], rd_b[2*CH_W-1:CH_W],
                                s1_c[2*CH_W-1:CH_W], s1_d[2*CH_W-1:CH_W]);
      blue_out    <= blend_chan(rd_a[CH_W-1:0], rd_b[CH_W-1:0],
                                s1_c[CH_W-1:0], s1_d[CH_W-1:0]);
    end
  end

endmodule

FILE: design/pfb_checker.sv
// port-level checks for the 2x2 blend filter and their binding
module pfb_checker
  import pfb_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             pix_valid,
  input logic             pix_stall,
  input logic             res_valid,
  input logic             res_stall,
  input logic [IDX_W-1:0] pixel_index,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // a held result keeps its index
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(pixel_index))
    else $error("result item changed while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result item present right after reset");

  // a config write starts the slot recompute, which holds off items
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> pix_stall)
    else $error("item taken right after a config write");

  // with the output empty at both sampled edges and no item taken at the first, no result can follow
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !res_valid && !(pix_valid && !pix_stall) ##1 !res_valid |=> !res_valid)
    else $error("unexpected result item");

endmodule

bind pixel_fade_blur_2x2 pfb_checker u_pfb_checker (.*);

FILE: verif/pixel_fade_blur_2x2_checker.sv
`timescale 1ns / 100ps
// scoreboard for the 2x2 blend filter: mirrors the line store and checks every result item
module pixel_fade_blur_2x2_checker
  import pfb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_LINES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_valid,
  input  logic             pix_stall,
  input  logic             frame_start,
  input  logic [CH_W-1:0]  red_in,
  input  logic [CH_W-1:0]  green_in,
  input  logic [CH_W-1:0]  blue_in,
  input  logic             res_valid,
  input  logic             res_stall,
  input  logic [IDX_W-1:0] pixel_index,
  input  logic [CH_W-1:0]  red_out,
  input  logic [CH_W-1:0]  green_out,
  input  logic [CH_W-1:0]  blue_out,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               outstanding,
  output int               fail_count
);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    pixel_t           color;
  } blend_item_t;

  blend_item_t      blend_q[$];
  pixel_t           line_copy [0:MAX_WIDTH];
  logic [CFG_W-1:0] width_cfg;
  logic [CFG_W-1:0] count_cfg;
  int unsigned      next_pos;
  pixel_t           prior_pix;
  int               errors = 0;

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
    if (v < DIM_MIN) return 32'(DIM_MIN);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  // a moved 1/2^sh of the way toward b, rounding down
  function automatic chan_t approach(chan_t a, chan_t b, int sh);
    int d;
    d = int'(b) - int'(a);
    return chan_t'(int'(a) + (d >>> sh));
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : track
    int unsigned w;
    int unsigned h;
    int unsigned frame_len;
    int unsigned depth;
    int unsigned q;
    int unsigned slot;
    pixel_t      here;
    pixel_t      up;
    pixel_t      up_next;
    blend_item_t want;
    if (rst) begin
      blend_q.delete();
      width_cfg = LINE_WIDTH_RST;
      count_cfg = LINE_COUNT_RST;
      next_pos  = 0;
      prior_pix = '0;
    end else begin
      if (res_valid && !res_stall) begin
        if (blend_q.size() == 0) begin
          $error("result item at index %0d with nothing expected", pixel_index);
          errors++;
        end else begin
          want = blend_q.pop_front();
          check_field("pixel_index", 32'(want.index), 32'(pixel_index));
          check_field("red_out", 32'(want.color[2*CH_W +: CH_W]), 32'(red_out));
          check_field("green_out", 32'(want.color[CH_W +: CH_W]), 32'(green_out));
          check_field("blue_out", 32'(want.color[0 +: CH_W]), 32'(blue_out));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LINE_WIDTH: width_cfg = cfg_data;
          REG_LINE_COUNT: count_cfg = cfg_data;
          default: ;
        endcase
      end
      if (pix_valid && !pix_stall) begin
        w         = clamp_dim(width_cfg, MAX_WIDTH);
        h         = clamp_dim(count_cfg, MAX_LINES);
        frame_len = w * h;
        depth     = w + 1;
        here      = {red_in, green_in, blue_in};
        q         = frame_start ? 0 : next_pos;
        if (q >= frame_len) q = 0;
        slot = q % depth;
        // this item is the lower-right neighbour of p = q - depth
        if (q >= depth && q - depth + 2 <= w * (h - 1)) begin
          up          = line_copy[slot];
          up_next     = line_copy[(slot + 1) % depth];
          want.index  = IDX_W'(q - depth);
          for (int k = 0; k < 3; k++) begin
            want.color[k*CH_W +: CH_W] = approach(
              approach(up[k*CH_W +: CH_W], up_next[k*CH_W +: CH_W], SHIFT_ROW),
              approach(prior_pix[k*CH_W +: CH_W], here[k*CH_W +: CH_W], SHIFT_ROW),
              SHIFT_COL);
          end
          blend_q = {blend_q, want};
        end
        line_copy[slot] = here;
        prior_pix       = here;
        next_pos        = (q + 1 >= frame_len) ? 0 : q + 1;
      end
    end
    outstanding <= blend_q.size();
    fail_count  <= errors;
  end

endmodule

FILE: verif/pixel_fade_blur_2x2_tb.sv
`timescale 1ns / 100ps
// testbench top for the 2x2 blend filter: clock, reset, pixel and register traffic, verdict
module pixel_fade_blur_2x2_tb;
  import pfb_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped index, the write is dropped
  localparam int SETTLE       = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASES       = 7;
  localparam int QUIET_PHASES = 2;
  localparam int WIDE_ITEMS   = 1060;

  logic             clk = 1'b0;
  logic             rst;
  logic             pix_valid;
  logic             pix_stall;
  logic             frame_start;
  logic [CH_W-1:0]  red_in;
  logic [CH_W-1:0]  green_in;
  logic [CH_W-1:0]  blue_in;
  logic             res_valid;
  logic             res_stall;
  logic [IDX_W-1:0] pixel_index;
  logic [CH_W-1:0]  red_out;
  logic [CH_W-1:0]  green_out;
  logic [CH_W-1:0]  blue_out;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               outstanding;
  int               fail_count;
  int               gap_rate = 0;
  int               stall_rate = 0;

  always #10 clk = ~clk;

  pixel_fade_blur_2x2 u_dut (.*);

  pixel_fade_blur_2x2_checker u_checker (.*);

  function automatic pixel_t edge_pixel(int i);
    case (i % 8)
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'hFF00FF;
      3: return 24'h00FF00;
      4: return 24'h0000FF;
      5: return 24'hFFFF00;
      6: return 24'h7F80FE;
      default: return 24'h01FE80;
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        0: px[k*CH_W +: CH_W] = '0;
        1: px[k*CH_W +: CH_W] = '1;
        default: px[k*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  // mostly small frames, with the clamp corners now and then
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CFG_W'(1);
      2: return '1;
      3: return CFG_W'(1024);
      4: return CFG_W'($urandom_range(0, 2047));
      default: return CFG_W'($urandom_range(2, 9));
    endcase
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 10;
      default: return 25;
    endcase
  endfunction

  // registers change only once the filter has drained
  task automatic settle_and_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic fs, input pixel_t px);
    if (gap_rate != 0 && $urandom_range(0, 99) < gap_rate) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    pix_valid   <= 1'b1;
    frame_start <= fs;
    red_in      <= px[2*CH_W +: CH_W];
    green_in    <= px[CH_W +: CH_W];
    blue_in     <= px[0 +: CH_W];
    do @(posedge clk); while (pix_stall);
  endtask

  initial begin
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_rate != 0 && $urandom_range(0, 99) < stall_rate) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int n_items;
    rst         = 1'b1;
    pix_valid   = 1'b0;
    frame_start = 1'b0;
    red_in      = '0;
    green_in    = '0;
    blue_in     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_LINE_WIDTH;
    cfg_data    = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frames of mostly corner colors: wraps past the frame end, then restarts mid-frame
    settle_and_write(REG_LINE_WIDTH, CFG_W'(3));
    settle_and_write(REG_LINE_COUNT, CFG_W'(3));
    settle_and_write(REG_SPARE, '1);
    for (int i = 0; i < 24; i++) send_pixel(i == 0 || i == 21, edge_pixel(i));
    pix_valid <= 1'b0;

    // widest line clamps to the full store, so every entry gets written here
    gap_rate   = 10;
    stall_rate = 5;
    settle_and_write(REG_LINE_WIDTH, '1);
    settle_and_write(REG_LINE_COUNT, '0);
    for (int i = 0; i < WIDE_ITEMS; i++) send_pixel(i == 0, rand_pixel());
    pix_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph >= PHASES - QUIET_PHASES) begin
        gap_rate   = 0;
        stall_rate = 0;
      end else begin
        gap_rate   = pick_rate();
        stall_rate = pick_rate();
      end
      case ($urandom_range(0, 3))
        0: settle_and_write(REG_LINE_WIDTH, pick_dim());
        1: settle_and_write(REG_LINE_COUNT, pick_dim());
        default: begin
          settle_and_write(REG_LINE_WIDTH, pick_dim());
          settle_and_write(REG_LINE_COUNT, pick_dim());
        end
      endcase
      if ($urandom_range(0, 7) == 0)
        settle_and_write(REG_SPARE, CFG_W'($urandom_range(0, 2047)));
      n_items = $urandom_range(15, 35);
      // position carries over unless a new frame is marked
      for (int i = 0; i < n_items; i++)
        send_pixel((i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 29) == 0,
                   rand_pixel());
      pix_valid <= 1'b0;
    end

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
